// File: rtl/sha256sh_pkg.sv
// ----------------------------------------------------------------------------
// sha256sh_pkg
// Shared types, constants and round tables for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256sh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	// core control request from the byte sequencer
	typedef struct packed {
		logic  push;
		word_t word;
		logic  start;
		logic  reinit;
	} core_ctl_t;

	typedef struct packed {
		logic  busy;
		hash_t hash;
	} core_sts_t;

	localparam hash_t HASH_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_MARK    = 8'h80;
	localparam logic [5:0] PAD_LEN_POS = 6'd56;
	localparam logic [5:0] BLOCK_LAST  = 6'd63;
	localparam logic [5:0] ROUND_LAST  = 6'd63;
	localparam logic [2:0] WORD_LAST   = 3'd7;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t round_k(input logic [5:0] i);
		case (i)
			6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

endpackage

// File: rtl/sha256sh_core.sv
// ----------------------------------------------------------------------------
// sha256sh_core
// Compression engine: 16-word schedule window, one round per cycle, hash state.
// ----------------------------------------------------------------------------
module sha256sh_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256sh_pkg::core_ctl_t ctl,
	output sha256sh_pkg::core_sts_t sts
);

	typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

	cstate_t                 state_q;
	logic [5:0]              rnd_q;
	sha256sh_pkg::hash_t     hash_q;
	sha256sh_pkg::word_t     w_q [16];
	sha256sh_pkg::hash_t     v_q;
	sha256sh_pkg::hash_t     v_next;
	sha256sh_pkg::word_t     w_new;

	always_comb begin
		sha256sh_pkg::word_t s0, s1, ch, maj, e0, e1, t1, t2;
		s0 = sha256sh_pkg::rotr(w_q[1], 7) ^ sha256sh_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha256sh_pkg::rotr(w_q[14], 17) ^ sha256sh_pkg::rotr(w_q[14], 19)
			^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		e1  = sha256sh_pkg::rotr(v_q[4], 6) ^ sha256sh_pkg::rotr(v_q[4], 11)
			^ sha256sh_pkg::rotr(v_q[4], 25);
		e0  = sha256sh_pkg::rotr(v_q[0], 2) ^ sha256sh_pkg::rotr(v_q[0], 13)
			^ sha256sh_pkg::rotr(v_q[0], 22);
		t1  = v_q[7] + e1 + ch + sha256sh_pkg::round_k(rnd_q) + w_q[0];
		t2  = e0 + maj;
		v_next[7] = v_q[6];
		v_next[6] = v_q[5];
		v_next[5] = v_q[4];
		v_next[4] = v_q[3] + t1;
		v_next[3] = v_q[2];
		v_next[2] = v_q[1];
		v_next[1] = v_q[0];
		v_next[0] = t1 + t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			hash_q  <= sha256sh_pkg::HASH_IV;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctl.reinit) hash_q <= sha256sh_pkg::HASH_IV;
					if (ctl.start) begin
						state_q <= C_ROUND;
						rnd_q   <= '0;
					end
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == sha256sh_pkg::ROUND_LAST) state_q <= C_ADD;
				end
				C_ADD: begin
					for (int k = 0; k < 8; k++) hash_q[k] <= hash_q[k] + v_q[k];
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// window and working variables carry no reset
	always_ff @(posedge clk) begin
		if (ctl.push || state_q == C_ROUND) begin
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j + 1];
			w_q[15] <= ctl.push ? ctl.word : w_new;
		end
		if (ctl.start) v_q <= hash_q;
		else if (state_q == C_ROUND) v_q <= v_next;
	end

	assign sts.busy = (state_q != C_IDLE);
	assign sts.hash = hash_q;

endmodule

// File: rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// SHA-256 of a byte stream: byte gathering, padding sequencer, digest output.
// ----------------------------------------------------------------------------
// The 64th byte of a block starts the shared round unit, which runs 64 rounds
// and the final add (the working variables load on the accepting edge) with
// s_tready low. A finish request (s_tuser = 1) pushes the padding one byte per
// cycle while the round unit is idle (up to 72 bytes, with one or two
// compressions between), then presents the eight digest words on the master
// side, one per accepted request, word 0 first, tlast on word 7. The block
// then holds the initial hash values again for the next message.
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast    // last_word
);

	typedef enum logic [2:0] {S_IDLE, S_MARK, S_ZERO, S_LEN, S_WAIT, S_OUT} state_t;

	state_t                    state_q;
	logic [5:0]                fill_q;
	logic [60:0]               msg_q;
	logic [63:0]               len_q;
	logic [2:0]                len_cnt_q;
	logic [2:0]                idx_q;
	logic [23:0]               word_q;
	logic                      push;
	logic [7:0]                pbyte;
	logic                      busy;
	logic                      in_acc;
	logic                      out_acc;
	sha256sh_pkg::core_ctl_t   ctl;
	sha256sh_pkg::core_sts_t   sts;

	assign busy     = sts.busy;
	assign s_tready = (state_q == S_IDLE) && !busy;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_OUT);
	assign out_acc  = m_tvalid && m_tready;
	assign m_tdata  = {5'd0, idx_q, sts.hash[idx_q]};
	assign m_tlast  = (idx_q == sha256sh_pkg::WORD_LAST);

	always_comb begin
		push  = 1'b0;
		pbyte = 8'h00;
		case (state_q)
			S_IDLE: begin
				push  = in_acc && !s_tuser;
				pbyte = s_tdata;
			end
			S_MARK: begin
				push  = !busy;
				pbyte = sha256sh_pkg::PAD_MARK;
			end
			S_ZERO: push = !busy && (fill_q != sha256sh_pkg::PAD_LEN_POS);
			S_LEN: begin
				push  = !busy;
				pbyte = len_q[63:56];
			end
			default: push = 1'b0;
		endcase
	end

	assign ctl.push   = push && (fill_q[1:0] == 2'd3);
	assign ctl.word   = {word_q, pbyte};
	assign ctl.start  = push && (fill_q == sha256sh_pkg::BLOCK_LAST);
	assign ctl.reinit = out_acc && m_tlast;

	sha256sh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			msg_q     <= '0;
			len_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			if (push) fill_q <= fill_q + 6'd1;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_tuser) state_q <= S_MARK;
						else msg_q <= msg_q + 61'd1;
					end
				end
				S_MARK: if (!busy) state_q <= S_ZERO;
				S_ZERO: begin
					if (!busy && fill_q == sha256sh_pkg::PAD_LEN_POS) begin
						state_q   <= S_LEN;
						len_cnt_q <= '0;
					end
				end
				S_LEN: begin
					if (!busy) begin
						len_cnt_q <= len_cnt_q + 3'd1;
						if (len_cnt_q == sha256sh_pkg::WORD_LAST) state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!busy) begin
						state_q <= S_OUT;
						idx_q   <= '0;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == sha256sh_pkg::WORD_LAST) begin
							state_q <= S_IDLE;
							msg_q   <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// byte assembly and length shifter
	always_ff @(posedge clk) begin
		if (push) word_q <= {word_q[15:0], pbyte};
		if (in_acc && s_tuser) len_q <= {msg_q, 3'b000};
		else if (state_q == S_LEN && !busy) len_q <= {len_q[55:0], 8'h00};
	end

	a_no_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !busy) else $error("byte pushed while core busy");

	a_start_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> ctl.push) else $error("start without final word of block");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> busy) else $error("core did not start");

	a_out_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!busy && !s_tready && fill_q == 6'd0))
		else $error("digest shown with work pending");

	a_reinit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.reinit |=> (state_q == S_IDLE && msg_q == 61'd0))
		else $error("state not cleared after digest");

endmodule

// File: sim/digest_board_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digest_board_pkg
// Digest prediction and word checking for the SHA-256 stream hasher bench.
// The board keeps its own SHA-256 state. It queues eight expected words per
// finish request and compares each returned word with the oldest one.
// ----------------------------------------------------------------------------
package digest_board_pkg;

	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	class digest_board;
		logic [31:0]  iv [8];
		logic [31:0]  kr [64];
		logic [31:0]  hv [8];
		logic [7:0]   blk [64];
		int unsigned  fill;
		logic [60:0]  msg_len;
		digest_word_t pending_q [$];
		int unsigned  errors;
		int unsigned  checked;

		function new();
			iv = '{
				32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
			};
			kr = '{
				32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
				32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
				32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
				32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
				32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
				32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
				32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
				32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
				32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
				32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
				32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
				32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
				32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
				32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
				32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
				32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
			};
			errors = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			hv = iv;
			fill = 0;
			msg_len = '0;
		endfunction

		function logic [31:0] ror(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [64];
			logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
			int i;
			for (i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (i = 16; i < 64; i++) begin
				s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
			e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
			for (i = 0; i < 64; i++) begin
				t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
					+ kr[i] + w[i];
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
			hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
		endfunction

		function void take_byte(logic [7:0] data);
			blk[fill] = data;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		endfunction

		function void note_request(logic cmd, logic [7:0] data);
			logic [63:0] bit_len;
			digest_word_t dw;
			if (cmd == CMD_ABSORB) begin
				take_byte(data);
				msg_len++;
				return;
			end
			bit_len = {msg_len, 3'b000};
			take_byte(8'h80);
			while (fill != 56)
				take_byte(8'h00);
			for (int i = 0; i < 8; i++)
				take_byte(bit_len[63 - 8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				dw.word = hv[i];
				dw.idx = 3'(i);
				dw.last = (i == 7);
				pending_q.push_back(dw);
			end
			restart();
		endfunction

		function int unsigned outstanding();
			return pending_q.size();
		endfunction

		task report(string what);
			errors++;
			$display("%0t mismatch: %s", $time, what);
		endtask

		task check_word(logic [31:0] word, logic [2:0] idx, logic last);
			digest_word_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected word %0d = %08h", idx, word));
				return;
			end
			want = pending_q.pop_front();
			checked++;
			if (word !== want.word)
				report($sformatf("word %0d is %08h, want %08h", want.idx, word, want.word));
			if (idx !== want.idx)
				report($sformatf("word index is %0d, want %0d", idx, want.idx));
			if (last !== want.last)
				report($sformatf("last flag on word %0d is %b, want %b", want.idx, last,
					want.last));
		endtask
	endclass

endpackage

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of sha256_stream_hasher_top.
// Short directed messages (empty, "abc", extreme bytes) are followed by
// random messages whose lengths cluster on the padding and block boundaries.
// Both sides idle at random; every digest word is checked against a
// SHA-256 model held by the board.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned ITEM_TARGET = 470;
	localparam int unsigned PAD_BOUNDARY_LENS [10] = '{
		55, 56, 57, 63, 64, 65, 119, 120, 127, 128
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	digest_board_pkg::digest_board board;
	bit          burst;
	int unsigned sent_items;
	int unsigned sent_msgs;

	sha256_stream_hasher_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#300000;
		$display("RESULT: ERROR");
		$finish;
	end

	// entered and left just after a falling edge
	task automatic send_request(input logic cmd, input logic [7:0] data);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		board.note_request(cmd, data);
		sent_items++;
		if (cmd == digest_board_pkg::CMD_FINISH)
			sent_msgs++;
		@(negedge clk);
	endtask

	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_request(digest_board_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)));
		send_request(digest_board_pkg::CMD_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// hold off until every queued digest word has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = burst ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_word(m_tdata[31:0], m_tdata[34:32], m_tlast);
			@(negedge clk);
		end
	end

	initial begin
		int unsigned len;
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = digest_board_pkg::CMD_ABSORB;
		burst = 1'b0;
		sent_items = 0;
		sent_msgs = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty message; byte on finish is don't-care
		send_request(digest_board_pkg::CMD_FINISH, 8'hff);
		// "abc"
		send_request(digest_board_pkg::CMD_ABSORB, 8'h61);
		send_request(digest_board_pkg::CMD_ABSORB, 8'h62);
		send_request(digest_board_pkg::CMD_ABSORB, 8'h63);
		send_request(digest_board_pkg::CMD_FINISH, 8'h00);
		// extreme byte values
		send_request(digest_board_pkg::CMD_ABSORB, 8'h00);
		send_request(digest_board_pkg::CMD_ABSORB, 8'hff);
		send_request(digest_board_pkg::CMD_FINISH, 8'h5a);
		drain();

		while (sent_items < ITEM_TARGET) begin
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 3)
				len = PAD_BOUNDARY_LENS[$urandom_range(0, 9)];
			else
				len = $urandom_range(0, 70);
			send_message(len);
			if ($urandom_range(0, 7) == 0)
				drain();
		end
		burst = 1'b0;
		drain();
		repeat (80) @(posedge clk);

		$display("%0d messages in %0d requests, %0d digest words compared, %0d mismatches",
			sent_msgs, sent_items, board.checked, board.errors);
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
